[rtl/core/ipsd_pkg.sv]
package ipsd_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 14;
  localparam int DRIVE_W  = 15;
  localparam int ERR_W    = 17;
  localparam int D1_W     = 18;
  localparam int D2_W     = 19;
  localparam int PP_W     = D1_W + GAIN_W + 1;
  localparam int PI_W     = ERR_W + GAIN_W + 1;
  localparam int PD_W     = D2_W + GAIN_W + 1;
  // three products plus growth headroom
  localparam int SUM_W    = PD_W + 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 8'd3;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd5120;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd179;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd1024;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 14'd7000;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP       = 14'd10000;

  typedef struct packed {
    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [SPEED_W-1:0] target_speed;
  } speed_word_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_signed;
    logic [LIMIT_W-1:0]        drive_magnitude;
    logic                      forward;
  } drive_word_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] drive_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] e;
    logic signed [D1_W-1:0]  d1;
    logic signed [D2_W-1:0]  d2;
  } diff_t;

  typedef struct packed {
    logic signed [PP_W-1:0] p;
    logic signed [PI_W-1:0] i;
    logic signed [PD_W-1:0] d;
  } prod_t;

endpackage

[rtl/core/incremental_pid_speed_drive_core.sv]
// Incremental velocity PID for a motor speed loop. Each speed word (measured and target
// encoder counts for one control tick) updates a three-deep error history, forms
// kp*(e-e1) + ki*e + kd*(e-2e1+e2) with unsigned fixed-point gains, truncates toward zero,
// adds the result to the drive accumulator and clamps it to +/- drive_limit (limits above
// 10000 act as 10000). A drive word carries the signed drive, its magnitude for PWM duty and
// a forward bit. While the drive output is not stalled, the core takes one speed word per
// cycle; each word passes through registered stages in order: history and differences,
// gain multipliers, term scaling, then the accumulate-and-clamp register, whose add and
// clamp closes the loop from one tick to the next. cfg_ready is always high. Gains and the
// limit must be written through the cfg port only while the core is idle; the core itself does not enforce this.
module incremental_pid_speed_drive_core #(
  parameter int GAIN_FRAC_BITS = ipsd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            speed_valid,
  output logic                            speed_ready,
  input  ipsd_pkg::speed_word_t           speed,
  output logic                            drive_valid,
  input  logic                            drive_ready,
  output ipsd_pkg::drive_word_t           drive,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  ipsd_pkg::cfg_t  cfg;
  ipsd_pkg::diff_t diff;
  ipsd_pkg::prod_t prod;
  logic            diff_valid;
  logic            diff_ready;
  logic            prod_valid;
  logic            prod_ready;

  ipsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipsd_err u_err (
    .clk         (clk),
    .rst         (rst),
    .speed_valid (speed_valid),
    .speed_ready (speed_ready),
    .speed       (speed),
    .diff_valid  (diff_valid),
    .diff_ready  (diff_ready),
    .diff        (diff)
  );

  ipsd_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff       (diff),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  ipsd_acc #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_acc (
    .clk         (clk),
    .rst         (rst),
    .drive_limit (cfg.drive_limit),
    .prod_valid  (prod_valid),
    .prod_ready  (prod_ready),
    .prod        (prod),
    .drive_valid (drive_valid),
    .drive_ready (drive_ready),
    .drive       (drive)
  );

endmodule

[rtl/core/ipsd_cfg.sv]
module ipsd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ipsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipsd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ipsd_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= ipsd_pkg::GAIN_P_RST;
      cfg.gain_i      <= ipsd_pkg::GAIN_I_RST;
      cfg.gain_d      <= ipsd_pkg::GAIN_D_RST;
      cfg.drive_limit <= ipsd_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ipsd_pkg::CFG_GAIN_P:      cfg.gain_p      <= cfg_data;
        ipsd_pkg::CFG_GAIN_I:      cfg.gain_i      <= cfg_data;
        ipsd_pkg::CFG_GAIN_D:      cfg.gain_d      <= cfg_data;
        ipsd_pkg::CFG_DRIVE_LIMIT: cfg.drive_limit <= cfg_data[ipsd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/ipsd_err.sv]
module ipsd_err (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  speed_valid,
  output logic                  speed_ready,
  input  ipsd_pkg::speed_word_t speed,
  output logic                  diff_valid,
  input  logic                  diff_ready,
  output ipsd_pkg::diff_t       diff
);

  logic signed [ipsd_pkg::ERR_W-1:0] err_now;
  logic signed [ipsd_pkg::ERR_W-1:0] err_last;
  logic signed [ipsd_pkg::ERR_W-1:0] err_prev;
  logic signed [ipsd_pkg::ERR_W-1:0] err_next;
  logic                              valid;
  logic                              load;

  assign speed_ready = !valid || diff_ready;
  assign load        = speed_valid && speed_ready;

  assign err_next = ipsd_pkg::ERR_W'(speed.target_speed)
                  - ipsd_pkg::ERR_W'(speed.measured_speed);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      err_now  <= '0;
      err_last <= '0;
      err_prev <= '0;
    end else begin
      if (load) begin
        err_now  <= err_next;
        err_last <= err_now;
        err_prev <= err_last;
      end
      if (load) begin
        valid <= 1'b1;
      end else if (diff_ready) begin
        valid <= 1'b0;
      end
    end
  end

  // differences come straight off the history, which only moves on accept
  assign diff_valid = valid;
  assign diff.e     = err_now;
  assign diff.d1    = ipsd_pkg::D1_W'(err_now) - ipsd_pkg::D1_W'(err_last);
  assign diff.d2    = ipsd_pkg::D2_W'(err_now) - (ipsd_pkg::D2_W'(err_last) <<< 1)
                    + ipsd_pkg::D2_W'(err_prev);

endmodule

[rtl/core/ipsd_mul.sv]
module ipsd_mul (
  input  logic            clk,
  input  logic            rst,
  input  ipsd_pkg::cfg_t  cfg,
  input  logic            diff_valid,
  output logic            diff_ready,
  input  ipsd_pkg::diff_t diff,
  output logic            prod_valid,
  input  logic            prod_ready,
  output ipsd_pkg::prod_t prod
);

  logic signed [ipsd_pkg::GAIN_W:0] gp;
  logic signed [ipsd_pkg::GAIN_W:0] gi;
  logic signed [ipsd_pkg::GAIN_W:0] gd;
  ipsd_pkg::prod_t                  prod_next;
  logic                             valid;
  logic                             load;

  assign gp = {1'b0, cfg.gain_p};
  assign gi = {1'b0, cfg.gain_i};
  assign gd = {1'b0, cfg.gain_d};

  assign prod_next.p = gp * diff.d1;
  assign prod_next.i = gi * diff.e;
  assign prod_next.d = gd * diff.d2;

  assign diff_ready = !valid || prod_ready;
  assign load       = diff_valid && diff_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (prod_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
    end
  end

  assign prod_valid = valid;

endmodule

[rtl/core/ipsd_acc.sv]
module ipsd_acc #(
  parameter int GAIN_FRAC_BITS = ipsd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ipsd_pkg::LIMIT_W-1:0]    drive_limit,
  input  logic                            prod_valid,
  output logic                            prod_ready,
  input  ipsd_pkg::prod_t                 prod,
  output logic                            drive_valid,
  input  logic                            drive_ready,
  output ipsd_pkg::drive_word_t           drive
);

  localparam int SUM_W  = ipsd_pkg::SUM_W;
  localparam int TERM_W = SUM_W - GAIN_FRAC_BITS;
  localparam int ACC_W  = TERM_W + 1;
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

  // term stage
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_biased;
  logic signed [TERM_W-1:0] term;
  logic                     term_valid;
  logic                     term_ready;
  logic                     term_load;

  // accumulate stage
  logic signed [ipsd_pkg::DRIVE_W-1:0] drive_accum;
  logic signed [ACC_W-1:0]             acc_sum;
  logic signed [ACC_W-1:0]             lim_pos;
  logic signed [ACC_W-1:0]             lim_neg;
  logic signed [ACC_W-1:0]             acc_clamped;
  logic signed [ipsd_pkg::DRIVE_W-1:0] drive_accum_next;
  logic [ipsd_pkg::LIMIT_W-1:0]        lim;
  logic                                out_valid;
  logic                                out_load;

  assign sum = SUM_W'(prod.p) + SUM_W'(prod.i) + SUM_W'(prod.d);
  // bias negative sums so the arithmetic shift truncates toward zero
  assign sum_biased = sum + (sum[SUM_W-1] ? ROUND_BIAS : {SUM_W{1'b0}});

  assign prod_ready = !term_valid || term_ready;
  assign term_load  = prod_valid && prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (term_load) begin
      term_valid <= 1'b1;
    end else if (term_ready) begin
      term_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (term_load) begin
      term <= sum_biased[SUM_W-1:GAIN_FRAC_BITS];
    end
  end

  assign lim     = (drive_limit > ipsd_pkg::LIMIT_CAP) ? ipsd_pkg::LIMIT_CAP : drive_limit;
  assign lim_pos = ACC_W'({1'b0, lim});
  assign lim_neg = -lim_pos;
  assign acc_sum = ACC_W'(drive_accum) + ACC_W'(term);

  always_comb begin
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  assign drive_accum_next = acc_clamped[ipsd_pkg::DRIVE_W-1:0];

  assign term_ready = !out_valid || drive_ready;
  assign out_load   = term_valid && term_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      drive_accum <= '0;
    end else begin
      if (out_load) begin
        drive_accum <= drive_accum_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (drive_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive.drive_signed    <= drive_accum_next;
      drive.drive_magnitude <= drive_accum_next[ipsd_pkg::DRIVE_W-1]
                             ? ipsd_pkg::LIMIT_W'(-drive_accum_next)
                             : drive_accum_next[ipsd_pkg::LIMIT_W-1:0];
      drive.forward         <= !drive_accum_next[ipsd_pkg::DRIVE_W-1];
    end
  end

  assign drive_valid = out_valid;

endmodule

[rtl/core/ipsd_checker.sv]
module ipsd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  drive_valid,
  input logic                  drive_ready,
  input ipsd_pkg::drive_word_t drive
);

  // no word can be in flight right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !drive_valid)
    else $error("drive word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    drive_valid && !drive_ready |=> drive_valid && $stable(drive))
    else $error("stalled drive word changed");

  a_dir: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> drive.forward == !drive.drive_signed[ipsd_pkg::DRIVE_W-1])
    else $error("direction bit disagrees with sign");

  a_mag: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (drive.forward
      ? ({1'b0, drive.drive_magnitude} == drive.drive_signed)
      : ({1'b0, drive.drive_magnitude} == -drive.drive_signed)))
    else $error("magnitude disagrees with signed drive");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> drive.drive_magnitude <= ipsd_pkg::LIMIT_CAP)
    else $error("drive beyond cap");

endmodule

bind incremental_pid_speed_drive_core ipsd_checker u_ipsd_checker (
  .clk         (clk),
  .rst         (rst),
  .drive_valid (drive_valid),
  .drive_ready (drive_ready),
  .drive       (drive)
);
